/* design/difference_operator_5x5_filter_top_assert.svh */
// Assertion macros shared by the checker files of the 5x5 difference filter.
// Both macros expect clk in their scope; DOF_ASSERT also expects rst_n there.
`ifndef DIFFERENCE_OPERATOR_5X5_FILTER_TOP_ASSERT_SVH
`define DIFFERENCE_OPERATOR_5X5_FILTER_TOP_ASSERT_SVH

// This property is checked only while reset is released.
`define DOF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// This property is checked at every edge, reset included.
`define DOF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

/* design/dof5x5_pkg.sv */
// Package for the 5x5 difference filter: sizes, register codes, kernels and arithmetic helpers.
// Has no dependencies. The top level and the checker import it.
package dof5x5_pkg;

    // Sizes
    localparam int DOF_MAX_WIDTH = 1024;
    localparam int KERNEL_SIZE   = 5;
    localparam int LINES         = KERNEL_SIZE - 1;
    localparam int PIX_W         = 8;
    localparam int CFG_W         = 11;
    localparam int CFG_IDX_W     = 1;
    localparam int COORD_W       = 10;
    localparam int HEIGHT_LIMIT  = 1024;
    localparam int MIN_SIZE      = KERNEL_SIZE;
    localparam int HALF_KERNEL   = KERNEL_SIZE / 2;

    // Register reset values
    localparam int WIDTH_RESET  = 500;
    localparam int HEIGHT_RESET = 600;

    // Scaling: divide by 56 as a shift by 3 and then a reciprocal multiply for 7
    localparam int SUM_W        = 14;
    localparam int RECIP_7      = 2341;
    localparam int RECIP_W      = 12;
    localparam int RECIP_SHIFT  = 14;
    localparam int EIGHTH_W     = SUM_W - 3;
    localparam int PROD_W       = EIGHTH_W + RECIP_W;
    localparam int EDGE_OFFSET  = 128;

    // Configuration register codes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [PIX_W-1:0]              pixel_t;
    typedef pixel_t [KERNEL_SIZE-1:0]      column_t;
    typedef column_t [KERNEL_SIZE-1:0]     window_t;
    typedef logic signed [SUM_W-1:0]       sum_t;

    // Horizontal and vertical difference kernels, row by row
    localparam int KERN_H [KERNEL_SIZE][KERNEL_SIZE] = '{
        '{-2, -3, -4, -3, -2},
        '{-1, -2, -3, -2, -1},
        '{ 0,  0,  0,  0,  0},
        '{ 1,  2,  3,  2,  1},
        '{ 2,  3,  4,  3,  2}
    };

    localparam int KERN_V [KERNEL_SIZE][KERNEL_SIZE] = '{
        '{-2, -1, 0, 1, 2},
        '{-3, -2, 0, 2, 3},
        '{-4, -3, 0, 3, 4},
        '{-3, -2, 0, 2, 3},
        '{-2, -1, 0, 1, 2}
    };

    // Weighted sum of the window with constant small weights.
    function automatic sum_t kernel_sum(input window_t win,
                                        input int kern [KERNEL_SIZE][KERNEL_SIZE]);
        int acc;
        acc = 0;
        for (int r = 0; r < KERNEL_SIZE; r++) begin
            for (int c = 0; c < KERNEL_SIZE; c++) begin
                acc += kern[r][c] * int'(win[r][c]);
            end
        end
        return sum_t'(acc);
    endfunction

    // Divide by 56 truncating toward zero, then add the offset.
    function automatic pixel_t scale_edge(input sum_t s);
        logic [SUM_W-1:0]    mag;
        logic [EIGHTH_W-1:0] eighth;
        logic [PROD_W-1:0]   prod;
        pixel_t              q;
        mag    = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
        eighth = mag[SUM_W-1:3];
        prod   = PROD_W'(eighth) * PROD_W'(RECIP_7);
        q      = PIX_W'(prod >> RECIP_SHIFT);
        return s[SUM_W-1] ? (PIX_W'(EDGE_OFFSET) - q) : (PIX_W'(EDGE_OFFSET) + q);
    endfunction

endpackage

/* design/dof5x5_ram.sv */
// Generic simple dual-port RAM: one write port and one read port with registered read data.
// Has no dependencies.
module dof5x5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/difference_operator_5x5_filter_top.sv */
// Top level of the 5x5 difference edge filter.
// Depends on dof5x5_pkg and instantiates dof5x5_ram for the line stores.
//
// Usage:
// Pixels enter in raster order on the input channel (in_valid, in_stall, pixel).
// A transfer takes place at a clock edge with in_valid high and in_stall low.
// Each pixel whose 5x5 window lies fully inside the frame yields one result on
// the output channel (out_valid, out_stall, horizontal_edge, vertical_edge,
// centre_row, centre_col). All other pixels yield no result.
// The result passes through stage 1, the window stage, the sum stage and the output
// registers. One pixel per clock is sustained while the receiver does not stall. The
// rate is set by the line-store RAM, which does one read and one write per pixel at
// neighboring columns. When the receiver stalls, the result holds and the internal
// stages fill up one after another. Only then does in_stall rise. The image_width and
// image_height registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data.
// The user must write them only while the block is idle; the block does not enforce it.
// cfg_ready is always high. Reset clears the counters, the window and all stage valids,
// and sets the size registers to 500 by 600. The line stores are not cleared. Every entry
// is written in a row before it is read in a later row.
module difference_operator_5x5_filter_top
    import dof5x5_pkg::*;
#(
    parameter int MAX_WIDTH = DOF_MAX_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [PIX_W-1:0]     pixel,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [PIX_W-1:0]     horizontal_edge,
    output logic [PIX_W-1:0]     vertical_edge,
    output logic [COORD_W-1:0]   centre_row,
    output logic [COORD_W-1:0]   centre_col,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int CNT_W   = $clog2(MAX_WIDTH);
    localparam int LIM_W   = (CNT_W + 1 > CFG_W) ? CNT_W + 1 : CFG_W;
    localparam int ROW_W   = $clog2(HEIGHT_LIMIT);
    localparam int LS_W    = LINES * PIX_W;

    // Configuration and counters
    logic [CFG_W-1:0]   image_width_reg;
    logic [CFG_W-1:0]   image_height_reg;
    logic [CNT_W-1:0]   col_count_reg, col_count_next;
    logic [ROW_W-1:0]   row_count_reg, row_count_next;
    logic [LIM_W-1:0]   width_eff;
    logic [CFG_W-1:0]   height_eff;
    logic [LIM_W-1:0]   col_plus;
    logic [CFG_W-1:0]   row_plus;
    logic               emit;
    logic [CNT_W-1:0]   col_centre;
    logic [ROW_W-1:0]   row_centre;

    // Handshake
    logic in_take, s1_go, s2_go, s3_go;
    logic s1_ready, s2_ready, s3_ready, out_ready;

    // Stage 1: pixel waiting for its line-store read
    logic               s1_valid_reg, s1_valid_next;
    logic               s1_emit_reg;
    pixel_t             s1_pixel_reg;
    logic [CNT_W-1:0]   s1_addr_reg;
    logic [COORD_W-1:0] s1_row_reg, s1_col_reg;

    // Stage 2: updated window
    logic               s2_valid_reg, s2_valid_next;
    window_t            window_reg, window_next;
    logic [COORD_W-1:0] s2_row_reg, s2_col_reg;

    // Stage 3: kernel sums
    logic               s3_valid_reg, s3_valid_next;
    sum_t               s3_sum_h_reg, s3_sum_v_reg;
    logic [COORD_W-1:0] s3_row_reg, s3_col_reg;

    // Output registers
    logic               out_valid_reg, out_valid_next;
    pixel_t             out_h_reg, out_v_reg;
    logic [COORD_W-1:0] out_row_reg, out_col_reg;

    // Line-store RAM
    logic [LS_W-1:0]    ram_rdata;
    logic [LS_W-1:0]    ram_wdata;
    column_t            new_column;

    // Each stage moves on when the next one is empty or moving.
    always_comb
    begin
        out_ready = !out_valid_reg || !out_stall;
        s3_ready  = !s3_valid_reg || out_ready;
        s2_ready  = !s2_valid_reg || s3_ready;
        s1_ready  = !s1_valid_reg || s2_ready;
        in_take   = in_valid && s1_ready;
        s1_go     = s1_valid_reg && s2_ready;
        s2_go     = s2_valid_reg && s3_ready;
        s3_go     = s3_valid_reg && out_ready;
    end

    assign in_stall  = !s1_ready;
    assign cfg_ready = 1'b1;

    // Stage valids
    always_comb
    begin
        s1_valid_next  = in_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
        s2_valid_next  = s1_go ? s1_emit_reg : (s2_go ? 1'b0 : s2_valid_reg);
        s3_valid_next  = s2_go ? 1'b1 : (s3_go ? 1'b0 : s3_valid_reg);
        out_valid_next = s3_go ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    // Frame sizes clamped to the supported range
    always_comb
    begin
        if (LIM_W'(image_width_reg) < LIM_W'(MIN_SIZE))
        begin
            width_eff = LIM_W'(MIN_SIZE);
        end
        else if (LIM_W'(image_width_reg) > LIM_W'(MAX_WIDTH))
        begin
            width_eff = LIM_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = LIM_W'(image_width_reg);
        end

        if (image_height_reg < CFG_W'(MIN_SIZE))
        begin
            height_eff = CFG_W'(MIN_SIZE);
        end
        else if (image_height_reg > CFG_W'(HEIGHT_LIMIT))
        begin
            height_eff = CFG_W'(HEIGHT_LIMIT);
        end
        else
        begin
            height_eff = image_height_reg;
        end
    end

    // Raster counters and the test for a full interior window
    always_comb
    begin
        col_plus   = LIM_W'(col_count_reg) + LIM_W'(1);
        row_plus   = CFG_W'(row_count_reg) + CFG_W'(1);
        emit       = (LIM_W'(col_count_reg) >= LIM_W'(LINES))
                  && (CFG_W'(row_count_reg) >= CFG_W'(LINES));
        col_centre = col_count_reg - CNT_W'(HALF_KERNEL);
        row_centre = row_count_reg - ROW_W'(HALF_KERNEL);
        if (col_plus >= width_eff)
        begin
            col_count_next = '0;
            row_count_next = (row_plus >= height_eff) ? '0 : ROW_W'(row_plus);
        end
        else
        begin
            col_count_next = CNT_W'(col_plus);
            row_count_next = row_count_reg;
        end
    end

    // Configuration registers and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= CFG_W'(WIDTH_RESET);
            image_height_reg <= CFG_W'(HEIGHT_RESET);
            col_count_reg    <= '0;
            row_count_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                    default:          ;
                endcase
            end
            if (in_take)
            begin
                col_count_reg <= col_count_next;
                row_count_reg <= row_count_next;
            end
        end
    end

    // The line-store word at a column packs the four previous rows, newest in the low byte.
    always_comb
    begin
        for (int k = 0; k < LINES; k++)
        begin
            new_column[k] = ram_rdata[(LINES - 1 - k) * PIX_W +: PIX_W];
        end
        new_column[KERNEL_SIZE-1] = s1_pixel_reg;
        ram_wdata = {ram_rdata[LS_W-PIX_W-1:0], s1_pixel_reg};
    end

    dof5x5_ram #(
        .WIDTH (LS_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (s1_go),
        .waddr (s1_addr_reg),
        .wdata (ram_wdata),
        .re    (in_take),
        .raddr (col_count_reg),
        .rdata (ram_rdata)
    );

    // The window shifts left by one column and takes the new column on the right.
    always_comb
    begin
        for (int k = 0; k < KERNEL_SIZE; k++)
        begin
            for (int l = 0; l < KERNEL_SIZE - 1; l++)
            begin
                window_next[k][l] = window_reg[k][l+1];
            end
            window_next[k][KERNEL_SIZE-1] = new_column[k];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            window_reg    <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_go)
            begin
                window_reg <= window_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_emit_reg  <= emit;
            s1_pixel_reg <= pixel;
            s1_addr_reg  <= col_count_reg;
            s1_row_reg   <= COORD_W'(row_centre);
            s1_col_reg   <= COORD_W'(col_centre);
        end
        if (s1_go)
        begin
            s2_row_reg <= s1_row_reg;
            s2_col_reg <= s1_col_reg;
        end
        if (s2_go)
        begin
            s3_sum_h_reg <= kernel_sum(window_reg, KERN_H);
            s3_sum_v_reg <= kernel_sum(window_reg, KERN_V);
            s3_row_reg   <= s2_row_reg;
            s3_col_reg   <= s2_col_reg;
        end
        if (s3_go)
        begin
            out_h_reg   <= scale_edge(s3_sum_h_reg);
            out_v_reg   <= scale_edge(s3_sum_v_reg);
            out_row_reg <= s3_row_reg;
            out_col_reg <= s3_col_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign horizontal_edge = out_h_reg;
    assign vertical_edge   = out_v_reg;
    assign centre_row      = out_row_reg;
    assign centre_col      = out_col_reg;

endmodule

/* design/dof5x5_checker.sv */
// Port-level checker for the 5x5 difference filter, bound to the top level.
// Depends on dof5x5_pkg and the macros in difference_operator_5x5_filter_top_assert.svh.
`include "difference_operator_5x5_filter_top_assert.svh"

module dof5x5_checker
    import dof5x5_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [PIX_W-1:0]     horizontal_edge,
    input logic [PIX_W-1:0]     vertical_edge,
    input logic [COORD_W-1:0]   centre_row,
    input logic [COORD_W-1:0]   centre_col,
    input logic                 cfg_valid,
    input logic                 cfg_ready
);

    // A clock edge seen in reset leaves no result offered at the edge after it.
    `DOF_ASSERT_ALWAYS(a_no_result_in_reset, !rst_n |=> !out_valid, "result valid during reset")

    // A stalled result stays offered with the same payload.
    `DOF_ASSERT(a_result_holds, out_valid && out_stall |=> out_valid && $stable(horizontal_edge) && $stable(vertical_edge) && $stable(centre_row) && $stable(centre_col), "stalled result changed")

    // The scaled responses lie within the range of the bounded kernel sums.
    `DOF_ASSERT(a_edge_range, out_valid |-> horizontal_edge >= 8'd24 && horizontal_edge <= 8'd232 && vertical_edge >= 8'd24 && vertical_edge <= 8'd232, "edge response out of range")

    // The configuration port never refuses a write transfer.
    `DOF_ASSERT(a_cfg_always_ready, cfg_valid |-> cfg_ready, "configuration write refused")

endmodule

bind difference_operator_5x5_filter_top dof5x5_checker u_dof5x5_checker (.*);

/* tb/tb_top.sv */
// Testbench for the 5x5 difference edge filter: pixel frames of random content and
// size are checked against a bit-exact filter predictor, with size register
// changes between phases. Depends on dof5x5_pkg and difference_operator_5x5_filter_top.
module tb_top;
    import dof5x5_pkg::*;

    localparam int     RESET_CYCLES      = 9;
    localparam int     RANDOM_PIXELS     = 450;
    localparam int     WIDE_PIXELS       = 256;
    localparam int     DRAIN_CYCLES      = 10;
    localparam int     WATCHDOG_LIMIT    = 2000;
    localparam int     EDGE_DIVISOR      = 56;
    localparam int     EDGE_BIAS         = 128;
    localparam int     WIDTH_AFTER_RESET = 500;
    localparam int     HEIGHT_AFTER_RESET = 600;
    localparam int     NEWEST            = KERNEL_SIZE - 1;
    localparam int     CFG_ALL_ONES      = (1 << CFG_W) - 1;
    localparam int     WIDE_PHASE        = 1;
    localparam int     TALL_PHASE        = 3;
    localparam pixel_t DARK              = '0;
    localparam pixel_t BRIGHT            = '1;

    typedef enum int {FILL_UNIFORM, FILL_BINARY, FILL_ROW_STEPS, FILL_COL_STEPS} fill_style_t;
    typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_LONG_HOLDS} rx_pattern_t;

    typedef struct packed {
        pixel_t               horiz;
        pixel_t               vert;
        logic [COORD_W-1:0]   row;
        logic [COORD_W-1:0]   col;
    } edge_result_t;

    // Block ports
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    pixel_t               pixel     = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    pixel_t               horizontal_edge;
    pixel_t               vertical_edge;
    logic [COORD_W-1:0]   centre_row;
    logic [COORD_W-1:0]   centre_col;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    cfg_reg_t             cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // Predictor state: line stores, window, raster counters and size registers
    pixel_t       line_mem [LINES][DOF_MAX_WIDTH];
    pixel_t       win [KERNEL_SIZE][KERNEL_SIZE];
    int unsigned  col_cnt    = 0;
    int unsigned  row_cnt    = 0;
    int unsigned  width_reg  = WIDTH_AFTER_RESET;
    int unsigned  height_reg = HEIGHT_AFTER_RESET;

    edge_result_t edge_expect_q [$];
    pixel_t       pixel_queue [$];
    int           error_count  = 0;
    int           quiet_cycles = 0;
    bit           pix_taken    = 1'b0;

    // Sender burst and receiver stall state
    int           burst_left = 0;
    int           gap_left   = 0;
    rx_pattern_t  rx_pattern = RX_FREE;
    int           pattern_left = 0;
    int           hold_left  = 0;
    bit           hold_on    = 1'b0;

    difference_operator_5x5_filter_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .pixel           (pixel),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .horizontal_edge (horizontal_edge),
        .vertical_edge   (vertical_edge),
        .centre_row      (centre_row),
        .centre_col      (centre_col),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Size registers saturate to the range the line stores and counters support.
    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
        if (v < KERNEL_SIZE)
            return KERNEL_SIZE;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Horizontal kernel weight at window row k and column l; the vertical kernel is
    // its transpose. Rows above the centre weigh negative and rows below positive,
    // growing by one toward the outer rows and toward the centre column.
    function automatic int diff_weight(input int k, input int l);
        int d;
        int bump;
        d    = k - HALF_KERNEL;
        bump = HALF_KERNEL - ((l > HALF_KERNEL) ? l - HALF_KERNEL : HALF_KERNEL - l);
        if (d == 0)
            return 0;
        return (d > 0) ? d + bump : d - bump;
    endfunction

    // Advance the filter by one pixel and queue the edge result it yields, if any.
    function automatic void filter_pixel(input pixel_t px);
        pixel_t       column [KERNEL_SIZE];
        int unsigned  w;
        int unsigned  h;
        int           horiz_sum;
        int           vert_sum;
        edge_result_t res;
        w = clamp_size(width_reg, DOF_MAX_WIDTH);
        h = clamp_size(height_reg, HEIGHT_LIMIT);

        // New window column, oldest row first, and the line store cascade.
        for (int k = 0; k < LINES; k++)
            column[k] = line_mem[LINES-1-k][col_cnt];
        column[NEWEST] = px;
        for (int k = LINES - 1; k > 0; k--)
            line_mem[k][col_cnt] = line_mem[k-1][col_cnt];
        line_mem[0][col_cnt] = px;

        for (int k = 0; k < KERNEL_SIZE; k++)
        begin
            for (int l = 0; l < NEWEST; l++)
                win[k][l] = win[k][l+1];
            win[k][NEWEST] = column[k];
        end

        // Only windows that lie fully inside the frame give a result.
        if (row_cnt >= LINES && col_cnt >= LINES)
        begin
            horiz_sum = 0;
            vert_sum  = 0;
            for (int k = 0; k < KERNEL_SIZE; k++)
            begin
                for (int l = 0; l < KERNEL_SIZE; l++)
                begin
                    horiz_sum += diff_weight(k, l) * int'(win[k][l]);
                    vert_sum  += diff_weight(l, k) * int'(win[k][l]);
                end
            end
            res.horiz = pixel_t'(horiz_sum / EDGE_DIVISOR + EDGE_BIAS);
            res.vert  = pixel_t'(vert_sum / EDGE_DIVISOR + EDGE_BIAS);
            res.row   = COORD_W'(row_cnt - HALF_KERNEL);
            res.col   = COORD_W'(col_cnt - HALF_KERNEL);
            edge_expect_q.push_back(res);
        end

        // Raster counters; a counter at or past a shrunken limit wraps on its next step.
        if (col_cnt + 1 >= w)
        begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
        end
        else
        begin
            col_cnt = col_cnt + 1;
        end
    endfunction

    // Pixels still needed to bring the raster counters back to the frame start.
    function automatic int pixels_to_frame_end();
        int unsigned w;
        int unsigned h;
        int          n;
        w = clamp_size(width_reg, DOF_MAX_WIDTH);
        h = clamp_size(height_reg, HEIGHT_LIMIT);
        if (col_cnt == 0 && row_cnt == 0)
            return 0;
        n = (col_cnt + 1 >= w) ? 1 : int'(w - col_cnt);
        if (row_cnt + 1 < h)
            n += int'((h - row_cnt - 1) * w);
        return n;
    endfunction

    // Mostly black or white, now and then any grey level.
    function automatic pixel_t binary_level();
        if ($urandom_range(0, 3) == 0)
            return pixel_t'($urandom);
        return $urandom_range(0, 1) ? BRIGHT : DARK;
    endfunction

    // Fill the pending pixel queue. Row and column steps drive the kernels to their extremes.
    function automatic void queue_pixels(input int n, input fill_style_t style);
        int unsigned w;
        int unsigned pos;
        pixel_t      level;
        pixel_t      col_level [DOF_MAX_WIDTH];
        w     = clamp_size(width_reg, DOF_MAX_WIDTH);
        pos   = col_cnt;
        level = binary_level();
        foreach (col_level[i])
            col_level[i] = binary_level();
        for (int i = 0; i < n; i++)
        begin
            if (pos == 0)
                level = binary_level();
            case (style)
                FILL_UNIFORM:   pixel_queue.push_back(pixel_t'($urandom));
                FILL_BINARY:    pixel_queue.push_back(binary_level());
                FILL_ROW_STEPS: pixel_queue.push_back(level);
                default:        pixel_queue.push_back(col_level[pos]);
            endcase
            pos = (pos + 1 >= w) ? 0 : pos + 1;
        end
    endfunction

    // Wait until every pixel is taken and every result has come, then let the pipe settle.
    task automatic wait_idle();
        while (pixel_queue.size() != 0 || in_valid || edge_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Write both size registers while the block is idle.
    task automatic resize(input int unsigned w_raw, input int unsigned h_raw);
        int n;
        // A wider row would read line store columns this frame never wrote,
        // so finish the frame first.
        if (clamp_size(w_raw, DOF_MAX_WIDTH) > clamp_size(width_reg, DOF_MAX_WIDTH))
        begin
            n = pixels_to_frame_end();
            if (n > 0)
            begin
                queue_pixels(n, FILL_UNIFORM);
                wait_idle();
            end
        end
        write_reg(REG_IMAGE_WIDTH, w_raw);
        write_reg(REG_IMAGE_HEIGHT, h_raw);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stimulus: reset, a directed frame, then random phases with size changes.
    initial
    begin
        int          random_count;
        int          n;
        int unsigned w_raw;
        int unsigned h_raw;
        int          r;
        foreach (win[k, l])
            win[k][l] = '0;
        foreach (line_mem[k, c])
            line_mem[k][c] = '0;
        random_count = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Sizes below the kernel saturate to 5 by 5. One frame with dark rows on top
        // and bright rows below gives the largest horizontal response.
        resize(0, 3);
        for (int row = 0; row < KERNEL_SIZE; row++)
        begin
            for (int c = 0; c < KERNEL_SIZE; c++)
                pixel_queue.push_back((row > HALF_KERNEL) ? BRIGHT :
                                      (row == HALF_KERNEL) ? 8'h5A : DARK);
        end
        wait_idle();

        for (int phase = 0; random_count < RANDOM_PIXELS; phase++)
        begin
            if (phase == WIDE_PHASE)
            begin
                // Oversized width saturates to the full line store: part of one wide row.
                resize(CFG_ALL_ONES, KERNEL_SIZE);
                queue_pixels(WIDE_PIXELS, FILL_UNIFORM);
                wait_idle();
            end
            else if (phase == TALL_PHASE)
            begin
                // Tallest frame, then an oversized height, then a height far below
                // the current row, which wraps at the row end.
                resize(KERNEL_SIZE, HEIGHT_LIMIT);
                queue_pixels(150, FILL_BINARY);
                wait_idle();
                resize(KERNEL_SIZE, CFG_ALL_ONES);
                queue_pixels(150, FILL_ROW_STEPS);
                wait_idle();
                resize(KERNEL_SIZE, KERNEL_SIZE + 1);
                queue_pixels(60, FILL_UNIFORM);
                wait_idle();
            end
            else
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    r = $urandom_range(0, 9);
                    w_raw = (r < 6) ? $urandom_range(5, 10) :
                            (r < 8) ? $urandom_range(11, 24) : $urandom_range(0, 4);
                    r = $urandom_range(0, 9);
                    h_raw = (r < 7) ? $urandom_range(5, 8) :
                            (r < 9) ? $urandom_range(0, 4) : $urandom_range(9, 16);
                    resize(w_raw, h_raw);
                end
                n = $urandom_range(20, 160);
                queue_pixels(n, fill_style_t'($urandom_range(0, 3)));
                random_count += n;
                wait_idle();
            end
        end

        wait_idle();
        if (error_count == 0 && edge_expect_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Pixel sender: bursts of random length separated by random gaps.
    always @(negedge clk)
    begin : pixel_driver
        if (!in_valid || pix_taken)
        begin
            if (gap_left > 0 || pixel_queue.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                in_valid <= 1'b0;
            end
            else
            begin
                in_valid <= 1'b1;
                pixel    <= pixel_queue.pop_front();
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else if ($urandom_range(0, 3) == 0)
                begin
                    burst_left = $urandom_range(100, 300);
                    gap_left   = 0;
                end
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = $urandom_range(0, 10);
                end
            end
        end
    end

    // Result receiver: the stall pattern switches between free running, random,
    // periodic and long holds.
    always @(negedge clk)
    begin : result_stall
        if (pattern_left == 0)
        begin
            rx_pattern   = rx_pattern_t'($urandom_range(0, 3));
            pattern_left = $urandom_range(20, 200);
        end
        else
        begin
            pattern_left--;
        end
        case (rx_pattern)
            RX_FREE:     out_stall <= 1'b0;
            RX_RANDOM:   out_stall <= 1'($urandom_range(0, 1));
            RX_PERIODIC: out_stall <= (pattern_left % 3 == 0);
            default:
            begin
                if (hold_left == 0)
                begin
                    hold_on   = !hold_on;
                    hold_left = hold_on ? $urandom_range(5, 30) : $urandom_range(1, 6);
                end
                else
                begin
                    hold_left--;
                end
                out_stall <= hold_on;
            end
        endcase
    end

    // Track transfers on all channels, predict, check results and watch for a hang.
    always @(posedge clk)
    begin : result_check
        edge_result_t got;
        edge_result_t want;
        bit           out_fire;
        bit           cfg_fire;
        pix_taken = rst_n && in_valid && !in_stall;
        out_fire  = rst_n && out_valid && !out_stall;
        cfg_fire  = rst_n && cfg_valid && cfg_ready;

        if (pix_taken)
            filter_pixel(pixel);

        if (cfg_fire)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  = 32'(cfg_data);
                REG_IMAGE_HEIGHT: height_reg = 32'(cfg_data);
                default:          ;
            endcase
        end

        if (out_fire)
        begin
            got = '{horizontal_edge, vertical_edge, centre_row, centre_col};
            if (edge_expect_q.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected edge result h=%0d v=%0d row=%0d col=%0d",
                         $time, got.horiz, got.vert, got.row, got.col);
            end
            else
            begin
                want = edge_expect_q.pop_front();
                if (got !== want)
                begin
                    error_count++;
                    $display("%0t: edge result mismatch: expected h=%0d v=%0d row=%0d col=%0d",
                             $time, want.horiz, want.vert, want.row, want.col);
                    $display("%0t:                       actual   h=%0d v=%0d row=%0d col=%0d",
                             $time, got.horiz, got.vert, got.row, got.col);
                end
            end
        end

        // Watchdog: too long without any transfer means the block has hung.
        if (pix_taken || out_fire || cfg_fire || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
